// ===== src/cidr_pkg.sv =====
package cidr_pkg;

    localparam int OCTET_MAX  = 255;
    localparam int PREFIX_MAX = 32;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [5:0] PREFIX_FULL = 6'(PREFIX_MAX);

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_ADDR   = 4'b0010,
        PH_PREFIX = 4'b0100,
        PH_TRAIL  = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  octet_count;
        logic [7:0]  octet_value;
        logic        digit_seen;
        logic [31:0] address_accum;
        logic [5:0]  prefix_accum;
        logic        slash_seen;
        logic        error_flag;
    } t_state;

    typedef struct packed {
        logic        parse_ok;
        logic [31:0] network_address;
        logic [31:0] net_mask;
        logic [5:0]  prefix_len;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:         PH_LEAD,
        octet_count:   2'd0,
        octet_value:   8'd0,
        digit_seen:    1'b0,
        address_accum: 32'd0,
        prefix_accum:  6'd0,
        slash_seen:    1'b0,
        error_flag:    1'b0
    };

    // prefix length p (0..32) to mask with p leading ones
    function automatic logic [31:0] mask_of(input logic [5:0] p);
        logic [31:0] m;
        begin
            if (p >= PREFIX_FULL) begin
                m = 32'hFFFF_FFFF;
            end else begin
                m = ~(32'hFFFF_FFFF >> p);
            end
            return m;
        end
    endfunction

endpackage

// ===== src/cidr_step.sv =====
module cidr_step
    import cidr_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_char,
    input  logic       i_present,
    input  logic       i_last,
    input  logic [5:0] i_fallback_len,
    output t_state     o_state,
    output t_result    o_result
);

    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [11:0] oct_sum;
    logic [9:0]  pfx_sum;
    t_phase      ph;
    t_state      ns;
    logic        ok;
    logic [31:0] addr;
    logic [5:0]  pfx;
    logic [31:0] mask;

    assign is_space  = (i_char == CH_SPACE) || (i_char == CH_TAB) ||
                       (i_char == CH_CR) || (i_char == CH_LF);
    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign digit_val = 4'(i_char - CH_ZERO);
    assign oct_sum   = 12'(i_state.octet_value) * 12'd10 + 12'(digit_val);
    assign pfx_sum   = 10'(i_state.prefix_accum) * 10'd10 + 10'(digit_val);

    always_comb begin
        ns = i_state;
        ph = i_state.phase;
        // first non-space character enters the address
        if (i_state.phase == PH_LEAD && !is_space) begin
            ph = PH_ADDR;
        end
        if (i_present && !i_state.error_flag) begin
            ns.phase = ph;
            unique case (ph)
                PH_LEAD: begin
                end
                PH_ADDR: begin
                    if (is_digit) begin
                        if (oct_sum > 12'(OCTET_MAX)) begin
                            ns.error_flag = 1'b1;
                        end else begin
                            ns.octet_value = oct_sum[7:0];
                            ns.digit_seen  = 1'b1;
                        end
                    end else if (i_char == CH_DOT) begin
                        if (!i_state.digit_seen || i_state.octet_count == 2'd3) begin
                            ns.error_flag = 1'b1;
                        end else begin
                            ns.address_accum = {i_state.address_accum[23:0],
                                                i_state.octet_value};
                            ns.octet_count   = i_state.octet_count + 2'd1;
                            ns.octet_value   = 8'd0;
                            ns.digit_seen    = 1'b0;
                        end
                    end else if (i_char == CH_SLASH) begin
                        if (!i_state.digit_seen || i_state.octet_count != 2'd3) begin
                            ns.error_flag = 1'b1;
                        end else begin
                            ns.address_accum = {i_state.address_accum[23:0],
                                                i_state.octet_value};
                            ns.octet_value   = 8'd0;
                            ns.digit_seen    = 1'b0;
                            ns.slash_seen    = 1'b1;
                            ns.phase         = PH_PREFIX;
                        end
                    end else if (is_space) begin
                        ns.phase = PH_TRAIL;
                    end else begin
                        ns.error_flag = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    if (is_digit) begin
                        if (pfx_sum > 10'(PREFIX_MAX)) begin
                            ns.error_flag = 1'b1;
                        end else begin
                            ns.prefix_accum = pfx_sum[5:0];
                            ns.digit_seen   = 1'b1;
                        end
                    end else if (is_space) begin
                        ns.phase = PH_TRAIL;
                    end else begin
                        ns.error_flag = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (!is_space) begin
                        ns.error_flag = 1'b1;
                    end
                end
                default: begin
                    ns.error_flag = 1'b1;
                end
            endcase
        end

        // close out the text from the updated state
        ok   = !ns.error_flag && (ns.phase != PH_LEAD);
        if (ns.slash_seen) begin
            ok   = ok && ns.digit_seen;
            addr = ns.address_accum;
            pfx  = ns.prefix_accum;
        end else begin
            ok   = ok && ns.digit_seen && (ns.octet_count == 2'd3);
            addr = {ns.address_accum[23:0], ns.octet_value};
            pfx  = (i_fallback_len > PREFIX_FULL) ? PREFIX_FULL : i_fallback_len;
        end
        mask = mask_of(pfx);

        o_result.parse_ok        = ok;
        o_result.network_address = ok ? (addr & mask) : 32'd0;
        o_result.net_mask        = ok ? mask : 32'd0;
        o_result.prefix_len      = ok ? pfx : 6'd0;

        o_state = i_last ? STATE_RESET : ns;
    end

endmodule

// ===== src/ipv4_cidr_parser.sv =====
// Flow: a request is processed out of the input register; a closing request
//   waits while the result register is full and undrained, then loads a result.
// Throughput: one character per cycle, barring such a wait; the parse step is
//   a single pass of multiply-by-ten, add and compare between both registers.
// Reset: synchronous active-low i_rst_n clears parse state, both valid flags
//   and sets the fallback prefix length to 32; payload registers are not reset.
module ipv4_cidr_parser
    import cidr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // character stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_s_tuser,   // [0] char_present
    input  logic        i_s_tlast,   // last_char

    // result stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [31:0] network_address, [63:32] net_mask,
                                     // [69:64] prefix_len, [71:70] zero
    output logic        o_m_tuser,   // [0] parse_ok

    // fallback prefix length write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_present;
    logic       r_in_last;

    // parser state and configuration
    t_state     r_state;
    t_state     n_state;
    logic [5:0] r_fallback_len;

    // result register
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic       process;
    logic       in_fire;
    logic       out_fire;

    // A request without last_char produces no result and never waits on the
    // master side; a closing request waits only while the result register is
    // still full and not being drained.
    assign out_fire   = r_out_valid && i_m_tready;
    assign process    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || process;
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign o_cfg_ready = 1'b1;

    cidr_step u_step (
        .i_state        (r_state),
        .i_char         (r_in_char),
        .i_present      (r_in_present),
        .i_last         (r_in_last),
        .i_fallback_len (r_fallback_len),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    // control: valid flags, parse state, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state        <= STATE_RESET;
            r_fallback_len <= PREFIX_FULL;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end

            if (process) begin
                r_state <= n_state;
            end

            // load a fresh result, or drop the one just taken
            if (process && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                r_fallback_len <= i_cfg_data;
            end
        end
    end

    // payload: hold the request until it is processed, the result until taken
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_char    <= i_s_tdata;
            r_in_present <= i_s_tuser;
            r_in_last    <= i_s_tlast;
        end
        if (process && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.parse_ok;
    assign o_m_tdata  = {2'b00, r_out.prefix_len, r_out.net_mask, r_out.network_address};

    // a closing request always leaves a result behind
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in_last |=> r_out_valid)
        else $error("closing request produced no result");

    // parse state is back at reset after a closing request
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in_last |=> (r_state == STATE_RESET))
        else $error("parse state not cleared after end of text");

    // the input side stalls only behind a closing request and a full result
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && r_in_last && r_out_valid && !i_m_tready)
        else $error("input stalled without cause");

    // rejected text carries zero fields; accepted text stays within /32
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.parse_ok ? (r_out.prefix_len <= PREFIX_FULL)
                                        : (o_m_tdata == 72'd0)))
        else $error("result fields inconsistent with parse_ok");

endmodule
